// ===== rtl/iwsw_pkg.sv =====
// types and constants for the instruction window sector wakeup unit
// no dependencies; used by the control block, the window cells and the checker
package iwsw_pkg;

  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned CFG_DATA_W       = 4;
  localparam int unsigned OP_W             = 2;
  localparam int unsigned RET_CNT_W        = 4;
  localparam int unsigned MAX_RETIRE_PORTS = 8;

  localparam logic [CFG_IDX_W-1:0]  CFG_RETIRE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_BLOCK_OFFSET = 1'd1;
  localparam logic [CFG_DATA_W-1:0] RETIRE_WIDTH_RST = 4'd4;
  localparam logic [CFG_DATA_W-1:0] BLOCK_OFFSET_RST = 4'd6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_RETIRE   = 2'd1,
    OP_RESPONSE = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RETIRE,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic insert;
    logic wake;
    logic shift;
  } cell_cmd_t;

endpackage

// ===== rtl/iwsw_cell.sv =====
// one window entry of the cell chain: load on insert, sector wakeup on response,
// shift towards the tail on retire; depends on iwsw_pkg
module iwsw_cell
  import iwsw_pkg::*;
#(
  parameter int unsigned IDX          = 0,
  parameter int unsigned CNT_W        = 8,
  parameter int unsigned SECTOR_COUNT = 8,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic                    item_bubble_i,
  input  logic [ADDRESS_BITS-1:0] item_addr_i,
  input  logic [SECTOR_COUNT-1:0] item_mask_i,
  input  logic [ADDRESS_BITS-1:0] block_mask_i,
  input  logic                    nb_ready_i,
  input  logic                    nb_bubble_i,
  input  logic [ADDRESS_BITS-1:0] nb_addr_i,
  input  logic [SECTOR_COUNT-1:0] nb_pend_i,
  output logic                    ready_o,
  output logic                    bubble_o,
  output logic [ADDRESS_BITS-1:0] addr_o,
  output logic [SECTOR_COUNT-1:0] pend_o
);

  logic                    ready_q, ready_d;
  logic                    bubble_q, bubble_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  logic [SECTOR_COUNT-1:0] pend_q, pend_d;
  logic                    hit;

  assign hit = !bubble_q && (((addr_q ^ item_addr_i) & block_mask_i) == '0);

  always_comb begin
    ready_d  = ready_q;
    bubble_d = bubble_q;
    addr_d   = addr_q;
    pend_d   = pend_q;
    if (cmd_i.shift) begin
      ready_d  = nb_ready_i;
      bubble_d = nb_bubble_i;
      addr_d   = nb_addr_i;
      pend_d   = nb_pend_i;
    end else if (cmd_i.insert && (count_i == CNT_W'(IDX))) begin
      ready_d  = item_bubble_i;
      bubble_d = item_bubble_i;
      addr_d   = item_bubble_i ? '0 : item_addr_i;
      pend_d   = item_bubble_i ? '0 : item_mask_i;
    end else if (cmd_i.wake && hit) begin
      pend_d = pend_q & ~item_mask_i;
      if (pend_d == '0) begin
        ready_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ready_q  <= ready_d;
    bubble_q <= bubble_d;
    addr_q   <= addr_d;
    pend_q   <= pend_d;
  end

  assign ready_o  = ready_q;
  assign bubble_o = bubble_q;
  assign addr_o   = addr_q;
  assign pend_o   = pend_q;

endmodule

// ===== rtl/iwsw_ctrl.sv =====
// sequencer of the window: config registers, item latch, occupancy count,
// retire loop and result register; depends on iwsw_pkg
module iwsw_ctrl
  import iwsw_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 128,
  parameter int unsigned SECTOR_COUNT = 8,
  parameter int unsigned ADDRESS_BITS = 48,
  parameter int unsigned CNT_W        = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic                    is_bubble_i,
  input  logic [ADDRESS_BITS-1:0] address_i,
  input  logic [SECTOR_COUNT-1:0] sector_mask_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    accepted_o,
  output logic [RET_CNT_W-1:0]    retired_count_o,
  output logic [CNT_W-1:0]        occupancy_o,
  output logic                    window_full_o,
  output logic                    window_empty_o,
  input  logic                    tail_ready_i,
  output cell_cmd_t               cmd_o,
  output logic [CNT_W-1:0]        count_o,
  output logic                    item_bubble_o,
  output logic [ADDRESS_BITS-1:0] item_addr_o,
  output logic [SECTOR_COUNT-1:0] item_mask_o,
  output logic [ADDRESS_BITS-1:0] block_mask_o
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);
  localparam logic [RET_CNT_W-1:0] MAX_RET_C = RET_CNT_W'(MAX_RETIRE_PORTS);

  state_e                  state_q, state_d;
  logic [CFG_DATA_W-1:0]   ret_width_q;
  logic [CFG_DATA_W-1:0]   blk_off_q;
  op_e                     op_q;
  logic                    bubble_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [SECTOR_COUNT-1:0] mask_q;
  logic [CNT_W-1:0]        count_q;
  logic [RET_CNT_W-1:0]    remain_q;
  logic [RET_CNT_W-1:0]    retired_q;
  logic                    acc_q;
  logic                    out_valid_q;
  logic                    out_acc_q;
  logic [RET_CNT_W-1:0]    out_ret_q;
  logic [CNT_W-1:0]        out_occ_q;
  logic                    out_full_q;
  logic                    out_empty_q;

  logic                    accept;
  logic                    step_ok;
  logic                    out_free;
  logic                    out_load;
  logic                    full;
  op_e                     in_op;

  assign in_op    = op_e'(operation_i);
  assign full     = (count_q == DEPTH_C);
  assign out_free = !out_valid_q || out_ready_i;
  assign step_ok  = (remain_q != '0) && (count_q != '0) && tail_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_op == OP_RETIRE) ? S_RETIRE : S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESULT;
      end
      S_RETIRE: begin
        if (!step_ok) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_EXEC: begin
        cmd_o.insert = (op_q == OP_INSERT) && !full;
        cmd_o.wake   = (op_q == OP_RESPONSE);
      end
      S_RETIRE: begin
        cmd_o.shift = step_ok;
      end
      S_RESULT: begin
        out_load = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_width_q <= RETIRE_WIDTH_RST;
      blk_off_q   <= BLOCK_OFFSET_RST;
      count_q     <= '0;
      remain_q    <= '0;
      retired_q   <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RETIRE_WIDTH: ret_width_q <= cfg_wdata_i;
          CFG_BLOCK_OFFSET: blk_off_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (accept) begin
        remain_q  <= (RET_CNT_W'(ret_width_q) > MAX_RET_C) ? MAX_RET_C
                                                            : RET_CNT_W'(ret_width_q);
        retired_q <= '0;
        acc_q     <= (in_op == OP_RETIRE) || (in_op == OP_RESPONSE) ||
                     ((in_op == OP_INSERT) && !full);
      end
      if (cmd_o.insert) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_o.shift) begin
        count_q   <= count_q - 1'b1;
        remain_q  <= remain_q - 1'b1;
        retired_q <= retired_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_op;
      bubble_q <= is_bubble_i;
      addr_q   <= address_i;
      mask_q   <= sector_mask_i;
    end
    if (out_load) begin
      out_acc_q   <= acc_q;
      out_ret_q   <= retired_q;
      out_occ_q   <= count_q;
      out_full_q  <= full;
      out_empty_q <= (count_q == '0);
    end
  end

  assign count_o         = count_q;
  assign item_bubble_o   = bubble_q;
  assign item_addr_o     = addr_q;
  assign item_mask_o     = mask_q;
  assign block_mask_o    = {ADDRESS_BITS{1'b1}} << blk_off_q;
  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign retired_count_o = out_ret_q;
  assign occupancy_o     = out_occ_q;
  assign window_full_o   = out_full_q;
  assign window_empty_o  = out_empty_q;

endmodule

// ===== rtl/instruction_window_sector_wakeup_unit.sv =====
// Instruction window with in-order retire and sector wakeup, built as a row of
// entry cells with the oldest entry in cell 0. A word is latched in the cycle it
// is accepted; insert, response and unused codes then pass the execute state and
// the result state, which loads the result register once the output is free. A
// retire passes the retire state, where the chain moves one place towards the
// tail per cycle while the tail cell is ready, and then the result state. A
// response checks every occupied cell against the block address in its execute
// state. One word is in work at a time, but the next is taken while a result
// waits at the output. No clearing pass after reset; the entry cells are written
// before being read. Depends on iwsw_pkg, iwsw_ctrl and iwsw_cell.
module instruction_window_sector_wakeup_unit
  import iwsw_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 128,
  parameter int unsigned SECTOR_COUNT = 8,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                 cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [OP_W-1:0]                       operation_i,
  input  logic                                  is_bubble_i,
  input  logic [ADDRESS_BITS-1:0]               address_i,
  input  logic [SECTOR_COUNT-1:0]               sector_mask_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  accepted_o,
  output logic [RET_CNT_W-1:0]                  retired_count_o,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]     occupancy_o,
  output logic                                  window_full_o,
  output logic                                  window_empty_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);

  cell_cmd_t               cmd;
  logic [CNT_W-1:0]        count;
  logic                    item_bubble;
  logic [ADDRESS_BITS-1:0] item_addr;
  logic [SECTOR_COUNT-1:0] item_mask;
  logic [ADDRESS_BITS-1:0] block_mask;

  logic                    ready_w  [WINDOW_DEPTH];
  logic                    bubble_w [WINDOW_DEPTH];
  logic [ADDRESS_BITS-1:0] addr_w   [WINDOW_DEPTH];
  logic [SECTOR_COUNT-1:0] pend_w   [WINDOW_DEPTH];

  iwsw_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SECTOR_COUNT (SECTOR_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .is_bubble_i     (is_bubble_i),
    .address_i       (address_i),
    .sector_mask_i   (sector_mask_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .retired_count_o (retired_count_o),
    .occupancy_o     (occupancy_o),
    .window_full_o   (window_full_o),
    .window_empty_o  (window_empty_o),
    .tail_ready_i    (ready_w[0]),
    .cmd_o           (cmd),
    .count_o         (count),
    .item_bubble_o   (item_bubble),
    .item_addr_o     (item_addr),
    .item_mask_o     (item_mask),
    .block_mask_o    (block_mask)
  );

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    // the last cell has no neighbour and keeps its own contents on a shift
    localparam int unsigned NB = (i == WINDOW_DEPTH - 1) ? i : i + 1;

    iwsw_cell #(
      .IDX          (i),
      .CNT_W        (CNT_W),
      .SECTOR_COUNT (SECTOR_COUNT),
      .ADDRESS_BITS (ADDRESS_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .count_i       (count),
      .item_bubble_i (item_bubble),
      .item_addr_i   (item_addr),
      .item_mask_i   (item_mask),
      .block_mask_i  (block_mask),
      .nb_ready_i    (ready_w[NB]),
      .nb_bubble_i   (bubble_w[NB]),
      .nb_addr_i     (addr_w[NB]),
      .nb_pend_i     (pend_w[NB]),
      .ready_o       (ready_w[i]),
      .bubble_o      (bubble_w[i]),
      .addr_o        (addr_w[i]),
      .pend_o        (pend_w[i])
    );
  end

endmodule

// ===== rtl/iwsw_checker.sv =====
// port-level checks for the instruction window sector wakeup unit, with its bind
// depends on iwsw_pkg; attached to instruction_window_sector_wakeup_unit
module iwsw_checker
  import iwsw_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 128
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              accepted_o,
  input logic [RET_CNT_W-1:0]              retired_count_o,
  input logic [$clog2(WINDOW_DEPTH+1)-1:0] occupancy_o,
  input logic                              window_full_o,
  input logic                              window_empty_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(occupancy_o) &&
                                    $stable(retired_count_o) && $stable(accepted_o))
    else $error("result word changed while stalled");

  // full and empty flags agree with the occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_full_o == (occupancy_o == CNT_W'(WINDOW_DEPTH))) &&
                    (window_empty_o == (occupancy_o == '0)))
    else $error("full or empty flag disagrees with occupancy");

  // bounds of occupancy and retire count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occupancy_o <= CNT_W'(WINDOW_DEPTH)) &&
                    (retired_count_o <= RET_CNT_W'(MAX_RETIRE_PORTS)))
    else $error("occupancy or retire count out of range");

  // a refused word never retires anything
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> retired_count_o == '0)
    else $error("refused word reports retired entries");

endmodule

bind instruction_window_sector_wakeup_unit iwsw_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH)
) u_iwsw_checker (.*);

// ===== sim/tb_instruction_window_sector_wakeup_unit.sv =====
// self-checking testbench for instruction_window_sector_wakeup_unit: directed and random words
// against a behavioural model of the window, with input idling and result back-pressure
// depends on iwsw_pkg and the rtl of the unit
module tb_instruction_window_sector_wakeup_unit;
  import iwsw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_DEPTH      = 128;
  localparam int unsigned SECT_W         = 8;
  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned OCC_W          = $clog2(WIN_DEPTH + 1);
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned EXP_DEPTH      = 16;

  typedef struct packed {
    logic              accepted;
    logic [RET_CNT_W-1:0] retired;
    logic [OCC_W-1:0]  occupancy;
    logic              full;
    logic              empty;
  } window_result_t;

  typedef struct packed {
    logic              ready;
    logic              bubble;
    logic [ADDR_W-1:0] addr;
    logic [SECT_W-1:0] pending;
  } window_entry_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_RETIRE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [OP_W-1:0]       operation_i = OP_INSERT;
  logic                  is_bubble_i = 1'b0;
  logic [ADDR_W-1:0]     address_i = '0;
  logic [SECT_W-1:0]     sector_mask_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  accepted_o;
  logic [RET_CNT_W-1:0]  retired_count_o;
  logic [OCC_W-1:0]      occupancy_o;
  logic                  window_full_o;
  logic                  window_empty_o;

  window_entry_t         win_q [WIN_DEPTH];
  int unsigned           win_head = 0;
  int unsigned           win_tail = 0;
  int unsigned           win_count = 0;
  logic [CFG_DATA_W-1:0] cfg_retire_width = RETIRE_WIDTH_RST;
  logic [CFG_DATA_W-1:0] cfg_block_offset = BLOCK_OFFSET_RST;

  window_result_t        exp_ring [EXP_DEPTH];
  int unsigned           exp_wr = 0;
  int unsigned           exp_rd = 0;
  logic [ADDR_W-1:0]     block_pool [8];
  int unsigned           mismatch_count = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           hold_requests = 0;
  int unsigned           hold_served = 0;
  int unsigned           hold_count = 0;
  int unsigned           stall_left = 0;
  bit                    send_gaps = 1'b1;
  bit                    sink_stalls = 1'b1;

  instruction_window_sector_wakeup_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .is_bubble_i    (is_bubble_i),
    .address_i      (address_i),
    .sector_mask_i  (sector_mask_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .retired_count_o(retired_count_o),
    .occupancy_o    (occupancy_o),
    .window_full_o  (window_full_o),
    .window_empty_o (window_empty_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic window_result_t window_step(op_e op, logic bub, logic [ADDR_W-1:0] a,
                                                 logic [SECT_W-1:0] m);
    window_result_t    res;
    logic [ADDR_W-1:0] blk_mask;
    int unsigned       lim;
    int unsigned       ix;
    res = '0;
    res.accepted = 1'b1;
    case (op)
      OP_INSERT: begin
        if (win_count == WIN_DEPTH) begin
          res.accepted = 1'b0;
        end else begin
          win_q[win_head].ready   = bub;
          win_q[win_head].bubble  = bub;
          win_q[win_head].addr    = bub ? {ADDR_W{1'b0}} : a;
          win_q[win_head].pending = bub ? {SECT_W{1'b0}} : m;
          win_head = (win_head + 1) % WIN_DEPTH;
          win_count++;
        end
      end
      OP_RETIRE: begin
        lim = (cfg_retire_width > MAX_RETIRE_PORTS) ? MAX_RETIRE_PORTS : cfg_retire_width;
        while (win_count != 0 && res.retired < lim && win_q[win_tail].ready) begin
          win_tail = (win_tail + 1) % WIN_DEPTH;
          win_count--;
          res.retired++;
        end
      end
      OP_RESPONSE: begin
        blk_mask = '1;
        blk_mask = blk_mask << cfg_block_offset;
        ix = win_tail;
        for (int unsigned k = 0; k < win_count; k++) begin
          if (!win_q[ix].bubble && (win_q[ix].addr & blk_mask) == (a & blk_mask)) begin
            win_q[ix].pending = win_q[ix].pending & ~m;
            if (win_q[ix].pending == '0) win_q[ix].ready = 1'b1;
          end
          ix = (ix + 1) % WIN_DEPTH;
        end
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase
    res.occupancy = OCC_W'(win_count);
    res.full      = (win_count == WIN_DEPTH);
    res.empty     = (win_count == 0);
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] block_jitter();
    logic [ADDR_W-1:0] jm;
    jm = '1;
    jm = ~(jm << $urandom_range(0, 13));
    return ADDR_W'($urandom) & jm;
  endfunction

  function automatic logic [SECT_W-1:0] awaited_mask();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r < 3) return SECT_W'(1) << $urandom_range(0, SECT_W - 1);
    return SECT_W'($urandom);
  endfunction

  task automatic compare_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp, act);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    window_result_t exp;
    if (exp_wr == exp_rd) begin
      $display("%0t: result word expected none got occupancy %0d", $time, occupancy_o);
      mismatch_count++;
    end else begin
      exp = exp_ring[exp_rd % EXP_DEPTH];
      exp_rd++;
      compare_field("accepted", 16'(exp.accepted), 16'(accepted_o));
      compare_field("retired_count", 16'(exp.retired), 16'(retired_count_o));
      compare_field("occupancy", 16'(exp.occupancy), 16'(occupancy_o));
      compare_field("window_full", 16'(exp.full), 16'(window_full_o));
      compare_field("window_empty", 16'(exp.empty), 16'(window_empty_o));
    end
  endtask

  // result side: checking, random stalls and the long hold-off
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i) check_result();
    if (hold_served != hold_requests) begin
      out_ready_i <= 1'b0;
      if (hold_count == LONG_HOLD) begin
        hold_count  <= 0;
        hold_served <= hold_served + 1;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL instruction_window_sector_wakeup_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(op_e op, logic bub, logic [ADDR_W-1:0] a, logic [SECT_W-1:0] m);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    is_bubble_i   <= bub;
    address_i     <= a;
    sector_mask_i <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_ring[exp_wr % EXP_DEPTH] = window_step(op, bub, a, m);
    exp_wr++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (exp_wr != exp_rd) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] rw, logic [CFG_DATA_W-1:0] bo);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RETIRE_WIDTH;
    cfg_wdata_i <= rw;
    @(posedge clk_i);
    cfg_retire_width = rw;
    cfg_idx_i   <= CFG_BLOCK_OFFSET;
    cfg_wdata_i <= bo;
    @(posedge clk_i);
    cfg_block_offset = bo;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(int unsigned ins_w, int unsigned ret_w, int unsigned rsp_w);
    int unsigned       pick;
    int unsigned       ix;
    op_e               op;
    logic              bub;
    logic [ADDR_W-1:0] a;
    logic [SECT_W-1:0] m;
    pick = $urandom_range(0, 99);
    bub  = 1'($urandom);
    a    = ADDR_W'({$urandom, $urandom});
    m    = SECT_W'($urandom);
    if (pick < ins_w) begin
      op  = OP_INSERT;
      bub = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) != 0) a = block_pool[$urandom_range(0, 7)] ^ block_jitter();
      m = awaited_mask();
    end else if (pick < ins_w + ret_w) begin
      op = OP_RETIRE;
    end else if (pick < ins_w + ret_w + rsp_w) begin
      op = OP_RESPONSE;
      if (win_count != 0 && $urandom_range(0, 4) < 3) begin
        ix = win_tail;
        if ($urandom_range(0, 1)) ix = (win_tail + $urandom_range(0, win_count - 1)) % WIN_DEPTH;
        a = win_q[ix].addr;
        if ($urandom_range(0, 1)) a = a ^ block_jitter();
        case ($urandom_range(0, 2))
          0: m = '1;
          1: m = win_q[ix].pending;
          default: ;
        endcase
      end else if ($urandom_range(0, 3) != 0) begin
        a = block_pool[$urandom_range(0, 7)] ^ block_jitter();
      end
    end else begin
      op = op_e'($urandom_range(0, 3));
    end
    send_word(op, bub, a, m);
  endtask

  task automatic run_traffic(logic [CFG_DATA_W-1:0] rw, logic [CFG_DATA_W-1:0] bo,
                             int unsigned ins_w, int unsigned ret_w, int unsigned rsp_w,
                             int unsigned words);
    set_config(rw, bo);
    repeat (words) send_random(ins_w, ret_w, rsp_w);
  endtask

  task automatic test_basic_ops();
    logic [ADDR_W-1:0] blk_a;
    blk_a = 48'h1234_5678_9A40;
    send_word(OP_RETIRE, 1'b0, '0, '0);
    send_word(OP_RESPONSE, 1'b0, '1, '1);
    send_word(OP_NONE, 1'b1, '1, '1);
    send_word(OP_INSERT, 1'b1, '1, '1);
    send_word(OP_INSERT, 1'b0, blk_a, 8'h00);
    send_word(OP_INSERT, 1'b0, blk_a + 8, 8'h81);
    send_word(OP_RETIRE, 1'b0, '0, '0);
    send_word(OP_RESPONSE, 1'b0, blk_a + 48'h30, 8'h01);
    send_word(OP_RETIRE, 1'b0, '0, '0);
    send_word(OP_RESPONSE, 1'b0, blk_a, 8'h80);
    repeat (4) send_word(OP_INSERT, 1'b1, '0, '0);
    send_word(OP_RETIRE, 1'b0, '0, '0);
    send_word(OP_RETIRE, 1'b0, '0, '0);
  endtask

  task automatic test_retire_limits();
    set_config(4'd0, BLOCK_OFFSET_RST);
    send_word(OP_INSERT, 1'b1, '0, '0);
    send_word(OP_RETIRE, 1'b0, '0, '0);
  endtask

  task automatic test_block_match();
    set_config(4'd4, 4'd0);
    send_word(OP_INSERT, 1'b0, '1, 8'h01);
    send_word(OP_RESPONSE, 1'b0, 48'hFFFF_FFFF_FFFE, 8'h01);
    send_word(OP_RESPONSE, 1'b0, '1, 8'h01);
    send_word(OP_RETIRE, 1'b0, '0, '0);
    set_config(4'd15, 4'd15);
    send_word(OP_INSERT, 1'b0, '0, 8'hFF);
    send_word(OP_RESPONSE, 1'b0, 48'h7FFF, 8'hF0);
    send_word(OP_RESPONSE, 1'b0, 48'h8000, 8'h0F);
    send_word(OP_RETIRE, 1'b0, '0, '0);
    send_word(OP_RESPONSE, 1'b0, 48'h0001, 8'h0F);
    send_word(OP_RETIRE, 1'b0, '0, '0);
  endtask

  task automatic test_traffic_mix();
    foreach (block_pool[i]) block_pool[i] = ADDR_W'({$urandom, $urandom});
    block_pool[0] = '0;
    block_pool[7] = '1;
    run_traffic(4'd4, 4'd6, 45, 25, 25, 150);
    run_traffic(4'd1, 4'd0, 70, 10, 15, 200);
    run_traffic(4'd8, 4'd12, 20, 40, 35, 200);
    run_traffic(4'd15, 4'd15, 60, 15, 20, 200);
    run_traffic(4'd0, 4'd3, 50, 20, 25, 100);
    run_traffic(4'd2, 4'd9, 15, 45, 35, 200);
    repeat (2) run_traffic(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 40, 30, 25, 100);
  endtask

  task automatic test_output_hold();
    wait_results_drained();
    hold_requests <= hold_requests + 1;
    repeat (24) send_random(40, 30, 25);
    wait_results_drained();
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    sink_stalls <= 1'b0;
    run_traffic(4'd8, 4'd6, 40, 30, 25, 300);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_retire_limits();
    test_block_match();
    test_traffic_mix();
    test_output_hold();
    test_full_rate();
    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && exp_wr == exp_rd) begin
      $display("PASS instruction_window_sector_wakeup_unit");
    end else begin
      $display("FAIL instruction_window_sector_wakeup_unit");
    end
    $finish;
  end

endmodule

// ===== instruction_window_sector_wakeup_unit.f =====
rtl/iwsw_pkg.sv
rtl/iwsw_cell.sv
rtl/iwsw_ctrl.sv
rtl/instruction_window_sector_wakeup_unit.sv
rtl/iwsw_checker.sv
sim/tb_instruction_window_sector_wakeup_unit.sv
